// ===== rtl/lcsc_pkg.sv =====
package lcsc_pkg;

   localparam int unsigned LEN_A = 25;
   localparam int unsigned LEN_B = 31;
   localparam int unsigned LEN_C = 33;
   localparam int unsigned LEN_D = 39;
   localparam int unsigned LEN_E = 40;

   localparam int unsigned NUM_REGS = 5;
   localparam int unsigned NUM_TAPS = 4;
   localparam int unsigned BITS_PER_BEAT = 8;

   localparam int unsigned SEED_A_W = 25;
   localparam int unsigned SEED_B_W = 31;
   localparam int unsigned SEED_C_W = 33;
   localparam int unsigned SEED_D_W = 39;
   localparam int unsigned SEED_E_W = 40;
   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_E = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_FIFTH = 3'd5;

   typedef int unsigned tap_row_type [NUM_TAPS];

   localparam int unsigned LENS [NUM_REGS] = '{LEN_A, LEN_B, LEN_C, LEN_D, LEN_E};

   localparam tap_row_type TAPS [NUM_REGS] = '{
      '{25, 20, 12, 8},
      '{31, 24, 16, 12},
      '{33, 28, 24, 4},
      '{39, 36, 28, 4},
      '{40, 35, 30, 3}
   };

   // output cell of an LFSR held zero-extended in 64 bits
   function automatic logic lfsr_out(input logic [63:0] r, input int unsigned len);
      return r[6'(len - 1)];
   endfunction

   // one Fibonacci step: shift up, feedback into cell 0, taps outside the register ignored
   function automatic logic [63:0] lfsr_step(input logic [63:0] r, input int unsigned len,
                                             input tap_row_type taps);
      logic        fb;
      logic [63:0] mask;
      fb = 1'b0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         if (taps[t] >= 1 && taps[t] <= len) begin
            fb = fb ^ r[6'(len - taps[t])];
         end
      end
      mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      return ({r[62:0], fb}) & mask;
   endfunction

   function automatic logic [1:0] t2_map(input logic [1:0] c);
      return {c[0], c[1] ^ c[0]};
   endfunction

endpackage

// ===== rtl/lfsr_combiner_stream_cipher.sv =====
// Channel  Dir  Beat fields (low bit up)                     Accepted when
// req      in   tdata: data_byte[7:0]; tuser: restart        req_tvalid & req_tready
// rsp      out  tdata: out_byte[7:0], key_byte[15:8]         rsp_tvalid & rsp_tready
// csr      in   csr_index selects register, csr_wdata value  csr_we
//
// One beat per cycle while rsp is not stalled; the result is registered and appears in the cycle after acceptance.
// Eight LFSR/carry steps are unrolled into the logic ahead of the result register.
// The output register takes a new beat whenever it is empty or being drained.
// Synchronous active-high reset clears LFSRs, carries, seeds and the output valid.
module lfsr_combiner_stream_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // data_byte[7:0]
   input  logic                                req_tuser,  // restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // out_byte[7:0], key_byte[15:8]
   input  logic                                csr_we,
   input  logic [lcsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [lcsc_pkg::LEN_A-1:0] rega_ff, rega_in;
   logic [lcsc_pkg::LEN_B-1:0] regb_ff, regb_in;
   logic [lcsc_pkg::LEN_C-1:0] regc_ff, regc_in;
   logic [lcsc_pkg::LEN_D-1:0] regd_ff, regd_in;
   logic [lcsc_pkg::LEN_E-1:0] rege_ff, rege_in;
   logic [1:0]                 carry_now_ff, carry_now_in;
   logic [1:0]                 carry_before_ff, carry_before_in;

   logic [lcsc_pkg::SEED_A_W-1:0] seed_a_ff;
   logic [lcsc_pkg::SEED_B_W-1:0] seed_b_ff;
   logic [lcsc_pkg::SEED_C_W-1:0] seed_c_ff;
   logic [lcsc_pkg::SEED_D_W-1:0] seed_d_ff;
   logic [lcsc_pkg::SEED_E_W-1:0] seed_e_ff;
   logic                          use_fifth_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [63:0] cur [lcsc_pkg::NUM_REGS];
      logic [2:0]  sum;
      logic        x;
      logic        b;
      logic [1:0]  cn;
      logic [1:0]  cb;
      logic [1:0]  nx;
      logic [7:0]  key;

      if (req_tuser) begin
         cur[0] = 64'(seed_a_ff);
         cur[1] = 64'(seed_b_ff);
         cur[2] = 64'(seed_c_ff);
         cur[3] = 64'(seed_d_ff);
         cur[4] = 64'(seed_e_ff);
         cn     = 2'b00;
         cb     = 2'b00;
      end else begin
         cur[0] = 64'(rega_ff);
         cur[1] = 64'(regb_ff);
         cur[2] = 64'(regc_ff);
         cur[3] = 64'(regd_ff);
         cur[4] = 64'(rege_ff);
         cn     = carry_now_ff;
         cb     = carry_before_ff;
      end
      for (int k = 0; k < lcsc_pkg::NUM_REGS; k++) begin
         cur[k] = cur[k] & ((lcsc_pkg::LENS[k] >= 64) ? '1 :
                            ((64'd1 << lcsc_pkg::LENS[k]) - 64'd1));
      end

      key = '0;
      for (int i = 0; i < lcsc_pkg::BITS_PER_BEAT; i++) begin
         sum = '0;
         x   = 1'b0;
         for (int k = 0; k < lcsc_pkg::NUM_REGS; k++) begin
            if (k < lcsc_pkg::NUM_REGS - 1 || use_fifth_ff) begin
               b   = lcsc_pkg::lfsr_out(cur[k], lcsc_pkg::LENS[k]);
               sum = sum + 3'(b);
               x   = x ^ b;
            end
         end
         nx     = 2'(sum + 3'(cn[1])) ^ cn ^ lcsc_pkg::t2_map(cb);
         key[i] = x ^ cn[0];
         for (int k = 0; k < lcsc_pkg::NUM_REGS; k++) begin
            if (k < lcsc_pkg::NUM_REGS - 1 || use_fifth_ff) begin
               cur[k] = lcsc_pkg::lfsr_step(cur[k], lcsc_pkg::LENS[k], lcsc_pkg::TAPS[k]);
            end
         end
         cb = cn;
         cn = nx;
      end

      rega_in         = cur[0][lcsc_pkg::LEN_A-1:0];
      regb_in         = cur[1][lcsc_pkg::LEN_B-1:0];
      regc_in         = cur[2][lcsc_pkg::LEN_C-1:0];
      regd_in         = cur[3][lcsc_pkg::LEN_D-1:0];
      rege_in         = cur[4][lcsc_pkg::LEN_E-1:0];
      carry_now_in    = cn;
      carry_before_in = cb;
      rsp_data_in     = {key, req_tdata ^ key};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rega_ff         <= '0;
         regb_ff         <= '0;
         regc_ff         <= '0;
         regd_ff         <= '0;
         rege_ff         <= '0;
         carry_now_ff    <= '0;
         carry_before_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            rega_ff         <= rega_in;
            regb_ff         <= regb_in;
            regc_ff         <= regc_in;
            regd_ff         <= regd_in;
            rege_ff         <= rege_in;
            carry_now_ff    <= carry_now_in;
            carry_before_ff <= carry_before_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff    <= '0;
         seed_b_ff    <= '0;
         seed_c_ff    <= '0;
         seed_d_ff    <= '0;
         seed_e_ff    <= '0;
         use_fifth_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            lcsc_pkg::CSR_SEED_A: begin
               seed_a_ff <= csr_wdata[lcsc_pkg::SEED_A_W-1:0];
            end
            lcsc_pkg::CSR_SEED_B: begin
               seed_b_ff <= csr_wdata[lcsc_pkg::SEED_B_W-1:0];
            end
            lcsc_pkg::CSR_SEED_C: begin
               seed_c_ff <= csr_wdata[lcsc_pkg::SEED_C_W-1:0];
            end
            lcsc_pkg::CSR_SEED_D: begin
               seed_d_ff <= csr_wdata[lcsc_pkg::SEED_D_W-1:0];
            end
            lcsc_pkg::CSR_SEED_E: begin
               seed_e_ff <= csr_wdata[lcsc_pkg::SEED_E_W-1:0];
            end
            lcsc_pkg::CSR_USE_FIFTH: begin
               use_fifth_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule
